// ===== rtl/vdst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdst_pkg
// Shared types and constants of the virtual disk sector translator.
// ----------------------------------------------------------------------------
package vdst_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int CFG_DW      = 41;
    localparam int CFG_AW      = 3;

    typedef enum logic [2:0] {
        OP_LOAD     = 3'd0,
        OP_SEEK_ABS = 3'd1,
        OP_SEEK_REL = 3'd2,
        OP_READ     = 3'd3,
        OP_WRITE    = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        ST_MAPPED   = 4'd0,
        ST_ZERO     = 4'd1,
        ST_RANGE    = 4'd2,
        ST_INDEX    = 4'd3,
        ST_BADSTATE = 4'd4,
        ST_NULLOFF  = 4'd5,
        ST_WRUNMAP  = 4'd6,
        ST_ABORT    = 4'd7,
        ST_SEEKOK   = 4'd8,
        ST_SEEKEND  = 4'd9,
        ST_LOADED   = 4'd10
    } t_status;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SECTOR_SIZE_LOG2   = 3'd0,
        CFG_BLOCK_SECTORS_LOG2 = 3'd1,
        CFG_CHUNK_RATIO_LOG2   = 3'd2,
        CFG_DISK_SECTORS       = 3'd3,
        CFG_TABLE_USED         = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        K_LOAD,
        K_SEEK,
        K_XFER,
        K_UNKNOWN
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_UNK,
        S_SEEK,
        S_SEEK2,
        S_XFER,
        S_INDEX,
        S_ADDR,
        S_DATA,
        S_EMIT
    } t_state;

    // entry state codes
    localparam logic [2:0] ENTRY_PARTIAL = 3'd7;
    localparam logic [2:0] ENTRY_UNDEF   = 3'd4;
    localparam logic [2:0] ENTRY_MAPPED  = 3'd6;
    localparam logic [2:0] ENTRY_UNMAP   = 3'd5;

    typedef struct packed {
        logic [3:0]  sector_size_log2;
        logic [4:0]  block_sectors_log2;
        logic [4:0]  chunk_ratio_log2;
        logic [40:0] disk_sectors;
        logic [12:0] table_used_entries;
    } t_cfg;

    // classified request: flag is absolute for seeks, write for transfers
    typedef struct packed {
        t_kind       kind;
        logic        flag;
        logic        last;
        logic        neg;
        logic [63:0] mag;
        logic [11:0] eidx;
        logic [63:0] eword;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic full;
    } t_qin;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_qout;

endpackage

// ===== rtl/vdst_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdst_if
// Request, response and configuration channels of the sector translator.
// ----------------------------------------------------------------------------
interface vdst_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [63:0] byte_offset;
    logic [11:0] entry_index;
    logic [63:0] entry_word;
    logic        last_of_run;

    modport source (output valid, operation, byte_offset, entry_index, entry_word,
                    last_of_run, input ready);
    modport sink (input valid, operation, byte_offset, entry_index, entry_word,
                  last_of_run, output ready);
endinterface

interface vdst_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [52:0] image_offset;
    logic [63:0] sector_number;
    logic        run_end;

    modport source (output valid, status, image_offset, sector_number, run_end,
                    input ready);
    modport sink (input valid, status, image_offset, sector_number, run_end,
                  output ready);
endinterface

interface vdst_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [40:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/vdst_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdst_front
// Accepts requests, decodes the operation and scales seek distances.
// ----------------------------------------------------------------------------
module vdst_front
    import vdst_pkg::*;
(
    vdst_req_if.sink    i_req,
    input  logic [3:0]  i_sector_size_log2,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_cmd        o_q_data
);

    logic [63:0] abs_off;

    assign i_req.ready = !i_q_full;
    assign o_q_push    = i_req.valid && !i_q_full;
    assign abs_off     = i_req.byte_offset[63] ? (64'd0 - i_req.byte_offset)
                                               : i_req.byte_offset;

    always_comb begin
        o_q_data.flag = 1'b0;
        case (t_op'(i_req.operation))
            OP_LOAD: begin
                o_q_data.kind = K_LOAD;
            end
            OP_SEEK_ABS: begin
                o_q_data.kind = K_SEEK;
                o_q_data.flag = 1'b1;
            end
            OP_SEEK_REL: begin
                o_q_data.kind = K_SEEK;
            end
            OP_READ: begin
                o_q_data.kind = K_XFER;
            end
            OP_WRITE: begin
                o_q_data.kind = K_XFER;
                o_q_data.flag = 1'b1;
            end
            default: begin
                o_q_data.kind = K_UNKNOWN;
            end
        endcase
        o_q_data.last  = i_req.last_of_run;
        o_q_data.neg   = i_req.byte_offset[63];
        o_q_data.mag   = abs_off >> i_sector_size_log2;
        o_q_data.eidx  = i_req.entry_index;
        o_q_data.eword = i_req.entry_word;
    end

endmodule

// ===== rtl/vdst_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdst_queue
// Short request queue between the decode front and the translation back.
// ----------------------------------------------------------------------------
module vdst_queue
    import vdst_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_qin  i_in,
    input  t_cmd  i_data,
    output logic  o_full,
    input  t_qout i_out_pop,
    output logic  o_valid,
    output t_cmd  o_data
);

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, n_wp;
    logic [Q_AW-1:0]   r_rp, n_rp;
    logic [Q_AW:0]     r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_in.push && !i_in.full;
    assign do_pop  = i_out_pop.pop && i_out_pop.valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == Q_AW'(Q_DEPTH-1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == Q_AW'(Q_DEPTH-1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/vdst_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdst_back
// Sequencer holding the allocation table, current sector and run state;
// carries out loads, seeks and sector translations.
// ----------------------------------------------------------------------------
module vdst_back
    import vdst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_cmd        i_q_data,
    output t_qout       o_q_pop,
    vdst_rsp_if.source  o_rsp
);

    logic [63:0] r_mem [TABLE_DEPTH];

    t_state      r_state, n_state;
    t_cmd        r_cmd;
    logic [63:0] r_cur, n_cur;
    logic        r_failed, n_failed;
    logic [63:0] r_dist;
    logic [40:0] r_blk;
    logic [40:0] r_inblk;
    logic [41:0] r_idx;
    logic [63:0] r_word;
    t_status     r_res_status, n_res_status;
    logic [52:0] r_res_off, n_res_off;
    logic [63:0] r_res_sec, n_res_sec;
    logic        r_o_valid;
    t_status     r_o_status;
    logic [52:0] r_o_off;
    logic [63:0] r_o_sec;
    logic        r_o_end;

    logic        q_pop, mem_we, mem_re, out_load;
    logic [63:0] total_ext;
    logic [63:0] seek_sum;
    logic        seek_end;
    logic        range_bad;
    logic [41:0] idx_sum;
    logic        idx_bad;
    logic [2:0]  ent_st;
    logic        ent_zero;
    logic        ent_null;
    logic [52:0] map_off;
    logic        data_ok;

    assign total_ext = {23'd0, i_cfg.disk_sectors};
    assign seek_sum  = r_cmd.flag ? r_dist : r_cur + r_dist;
    assign seek_end  = !seek_sum[63] && (seek_sum >= total_ext);
    assign range_bad = r_cur[63] || (r_cur >= total_ext);
    assign idx_sum   = {1'b0, r_blk} + {1'b0, r_blk >> i_cfg.chunk_ratio_log2};
    assign idx_bad   = (r_idx >= {29'd0, i_cfg.table_used_entries})
                    || (r_idx >= 42'(TABLE_DEPTH));
    assign ent_st    = r_word[2:0];
    assign ent_zero  = (ent_st <= 3'd3) || (ent_st == ENTRY_UNMAP);
    assign ent_null  = (r_word[63:20] == '0);
    assign map_off   = {r_word[52:20], 20'd0}
                     + (53'(r_inblk) << i_cfg.sector_size_log2);
    assign data_ok   = ent_zero ? !r_cmd.flag : (ent_st == ENTRY_MAPPED) && !ent_null;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_data.kind)
                        K_LOAD:  n_state = S_LOAD;
                        K_SEEK:  n_state = S_SEEK;
                        K_XFER:  n_state = S_XFER;
                        default: n_state = S_UNK;
                    endcase
                end
            end
            S_LOAD:  n_state = S_EMIT;
            S_UNK:   n_state = S_EMIT;
            S_SEEK:  n_state = S_SEEK2;
            S_SEEK2: n_state = S_EMIT;
            S_XFER:  n_state = (r_failed || range_bad) ? S_EMIT : S_INDEX;
            S_INDEX: n_state = S_ADDR;
            S_ADDR:  n_state = idx_bad ? S_EMIT : S_DATA;
            S_DATA:  n_state = S_EMIT;
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop    = (r_state == S_IDLE) && i_q_valid;
        mem_we   = (r_state == S_LOAD) && ({20'd0, r_cmd.eidx} < 32'(TABLE_DEPTH));
        mem_re   = (r_state == S_ADDR) && !idx_bad;
        out_load = (r_state == S_EMIT) && (!r_o_valid || o_rsp.ready);
    end

    assign o_q_pop.valid = i_q_valid;
    assign o_q_pop.pop   = q_pop;

    // sector state and result
    always_comb begin
        n_cur        = r_cur;
        n_failed     = r_failed;
        n_res_status = r_res_status;
        n_res_off    = r_res_off;
        n_res_sec    = r_res_sec;
        case (r_state)
            S_LOAD: begin
                n_res_status = ST_LOADED;
                n_res_off    = '0;
                n_res_sec    = r_cur;
            end
            S_UNK: begin
                n_res_status = ST_SEEKEND;
                n_res_off    = '0;
                n_res_sec    = r_cur;
            end
            S_SEEK2: begin
                n_cur        = seek_sum;
                n_failed     = 1'b0;
                n_res_status = seek_end ? ST_SEEKEND : ST_SEEKOK;
                n_res_off    = '0;
                n_res_sec    = seek_sum;
            end
            S_XFER: begin
                n_res_off = '0;
                n_res_sec = r_cur;
                if (r_failed) begin
                    n_res_status = ST_ABORT;
                    n_failed     = !r_cmd.last;
                end else if (range_bad) begin
                    n_res_status = ST_RANGE;
                    n_failed     = !r_cmd.last;
                end
            end
            S_ADDR: begin
                if (idx_bad) begin
                    n_res_status = ST_INDEX;
                    n_failed     = !r_cmd.last;
                end
            end
            S_DATA: begin
                n_res_off = '0;
                if (ent_zero) begin
                    n_res_status = r_cmd.flag ? ST_WRUNMAP : ST_ZERO;
                end else if (ent_st != ENTRY_MAPPED) begin
                    n_res_status = ST_BADSTATE;
                end else if (ent_null) begin
                    n_res_status = ST_NULLOFF;
                end else begin
                    n_res_status = ST_MAPPED;
                    n_res_off    = map_off;
                end
                if (data_ok) begin
                    n_cur = r_cur + 64'd1;
                end else begin
                    n_failed = !r_cmd.last;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_failed  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_failed <= n_failed;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_cmd <= i_q_data;
        end
        if (r_state == S_SEEK) begin
            r_dist <= r_cmd.neg ? (64'd0 - r_cmd.mag) : r_cmd.mag;
        end
        if (r_state == S_XFER) begin
            r_blk   <= r_cur[40:0] >> i_cfg.block_sectors_log2;
            r_inblk <= r_cur[40:0] & ((41'd1 << i_cfg.block_sectors_log2) - 41'd1);
        end
        if (r_state == S_INDEX) begin
            r_idx <= idx_sum;
        end
        r_res_status <= n_res_status;
        r_res_off    <= n_res_off;
        r_res_sec    <= n_res_sec;
        if (out_load) begin
            r_o_status <= r_res_status;
            r_o_off    <= r_res_off;
            r_o_sec    <= r_res_sec;
            r_o_end    <= r_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[TABLE_AW'(r_cmd.eidx)] <= r_cmd.eword;
        end
        if (mem_re) begin
            r_word <= r_mem[TABLE_AW'(r_idx)];
        end
    end

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.image_offset  = r_o_off;
    assign o_rsp.sector_number = r_o_sec;
    assign o_rsp.run_end       = r_o_end;

    a_advance_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA && data_ok) |=> (r_cur == $past(r_cur) + 64'd1))
        else $error("mapped or zero-fill sector did not advance by one");

    a_abort_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XFER && r_failed) |=> $stable(r_cur))
        else $error("aborted request moved the current sector");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |-> (r_idx < {29'd0, i_cfg.table_used_entries}))
        else $error("table read beyond entries in use");

    a_seek_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEEK2) |=> !r_failed)
        else $error("seek left the run marked failed");

endmodule

// ===== rtl/virtual_disk_sector_translator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtual_disk_sector_translator_unit
// Top level: configuration registers, decode front, request queue and
// translation back end.
// ----------------------------------------------------------------------------
// One request is handled at a time by the back-end sequencer, each kind of
// request passing its own states before the emit state; a full translation
// goes through the transfer, index, address and data states, since the table is
// read through a registered memory port. The front decodes up to two further
// requests into the queue meanwhile; a finished response waits in its output
// register, and the next one holds in the emit state until it is taken.
// The table has no reset; every entry must be loaded before it is used.
// Configuration writes are taken in any cycle and belong to idle periods.
module virtual_disk_sector_translator_unit
    import vdst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    vdst_req_if.sink    i_req,
    vdst_rsp_if.source  o_rsp,
    vdst_cfg_if.sink    i_cfg
);

    t_cfg  r_cfg;
    t_qin  q_in;
    t_qout q_out;
    t_cmd  q_wdata;
    t_cmd  q_rdata;
    logic  q_full;
    logic  q_valid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sector_size_log2   <= 4'd9;
            r_cfg.block_sectors_log2 <= 5'd12;
            r_cfg.chunk_ratio_log2   <= 5'd11;
            r_cfg.disk_sectors       <= '0;
            r_cfg.table_used_entries <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_SECTOR_SIZE_LOG2:   r_cfg.sector_size_log2   <= i_cfg.data[3:0];
                CFG_BLOCK_SECTORS_LOG2: r_cfg.block_sectors_log2 <= i_cfg.data[4:0];
                CFG_CHUNK_RATIO_LOG2:   r_cfg.chunk_ratio_log2   <= i_cfg.data[4:0];
                CFG_DISK_SECTORS:       r_cfg.disk_sectors       <= i_cfg.data[CFG_DW-1:0];
                CFG_TABLE_USED:         r_cfg.table_used_entries <= i_cfg.data[12:0];
                default: begin
                end
            endcase
        end
    end

    assign q_in.full = q_full;

    vdst_front u_front (
        .i_req              (i_req),
        .i_sector_size_log2 (r_cfg.sector_size_log2),
        .i_q_full           (q_full),
        .o_q_push           (q_in.push),
        .o_q_data           (q_wdata)
    );

    vdst_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (q_in),
        .i_data    (q_wdata),
        .o_full    (q_full),
        .i_out_pop (q_out),
        .o_valid   (q_valid),
        .o_data    (q_rdata)
    );

    vdst_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_out),
        .o_rsp     (o_rsp)
    );

endmodule
